// File: rtl/core/kps_pkg.sv
package kps_pkg;

	localparam int DEFAULT_NUM_ROWS = 4;
	localparam int DEFAULT_NUM_COLS = 3;

	localparam logic [7:0] KEY_SHUTDOWN = 8'h64;
	localparam logic [7:0] KEY_STAR     = 8'h2A;
	localparam logic [7:0] KEY_NONE     = 8'h00;

	localparam logic [3:0]  DEBOUNCE_RESET   = 4'd7;
	localparam logic [1:0]  RELEASE_RESET    = 2'd1;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;

	localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] CFG_RELEASE    = 2'd1;
	localparam logic [1:0] CFG_LONG_PRESS = 2'd2;

	localparam logic [1:0] REL_NONE   = 2'd0;
	localparam logic [1:0] REL_ANY    = 2'd1;
	localparam logic [1:0] REL_MIDDLE = 2'd2;

	localparam logic [2:0] STAR_ROW = 3'd3;
	localparam logic [2:0] STAR_COL = 3'd0;
	localparam logic [2:0] MID_COL  = 3'd1;

	typedef enum logic [1:0] {
		PH_DEBOUNCE = 2'd0,
		PH_HOLD     = 2'd1,
		PH_RELEASE  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [3:0]  debounce_samples;
		logic [1:0]  release_mode;
		logic [15:0] long_press_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] key_code;
		logic       key_valid;
		logic [3:0] row_drive;
	} res_t;

	function automatic logic [7:0] key_at(input logic [2:0] r, input logic [2:0] c);
		logic [7:0] k;
		k = KEY_NONE;
		unique case ({r, c})
			{3'd0, 3'd0}: k = "1";
			{3'd0, 3'd1}: k = "2";
			{3'd0, 3'd2}: k = "3";
			{3'd1, 3'd0}: k = "4";
			{3'd1, 3'd1}: k = "5";
			{3'd1, 3'd2}: k = "6";
			{3'd2, 3'd0}: k = "7";
			{3'd2, 3'd1}: k = "8";
			{3'd2, 3'd2}: k = "9";
			{3'd3, 3'd0}: k = KEY_STAR;
			{3'd3, 3'd1}: k = "0";
			{3'd3, 3'd2}: k = "#";
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

	function automatic logic column_bit(input logic [2:0] levels, input logic [2:0] c);
		logic b;
		b = 1'b1;
		unique case (c)
			3'd0: b = levels[0];
			3'd1: b = levels[1];
			3'd2: b = levels[2];
			default: b = 1'b1;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/core/kps_scan_core.sv
module kps_scan_core #(
	parameter int NUM_ROWS = kps_pkg::DEFAULT_NUM_ROWS,
	parameter int NUM_COLS = kps_pkg::DEFAULT_NUM_COLS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [2:0]    levels,
	input  kps_pkg::cfg_t cfg,
	output kps_pkg::res_t res
);
	import kps_pkg::*;

	localparam int RW = $clog2(NUM_ROWS);
	localparam int CW = $clog2(NUM_COLS);

	logic [RW-1:0] scan_row_q, scan_row_d;
	logic [CW-1:0] scan_col_q, scan_col_d;
	phase_t        phase_q, phase_d;
	logic          last_level_q, last_level_d;
	logic [3:0]    stable_cnt_q, stable_cnt_d;
	logic [15:0]   hold_cnt_q, hold_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q   <= '0;
			scan_col_q   <= '0;
			phase_q      <= PH_DEBOUNCE;
			last_level_q <= 1'b0;
			stable_cnt_q <= '0;
			hold_cnt_q   <= '0;
		end else if (step) begin
			scan_row_q   <= scan_row_d;
			scan_col_q   <= scan_col_d;
			phase_q      <= phase_d;
			last_level_q <= last_level_d;
			stable_cnt_q <= stable_cnt_d;
			hold_cnt_q   <= hold_cnt_d;
		end
	end

	always_comb begin
		logic [2:0]    row3;
		logic [2:0]    col3;
		logic          pin;
		logic [3:0]    cnt;
		logic [15:0]   hold_inc;
		logic [7:0]    key;
		logic          wait_rel;
		logic          go_next_row;
		logic [RW-1:0] row_inc;

		row3        = 3'(scan_row_q);
		col3        = 3'(scan_col_q);
		pin         = column_bit(levels, col3);
		key         = key_at(row3, col3);
		cnt         = '0;
		hold_inc    = '0;
		wait_rel    = 1'b0;
		go_next_row = 1'b0;
		row_inc     = (scan_row_q == RW'(NUM_ROWS - 1)) ? '0 : scan_row_q + RW'(1);

		scan_row_d   = scan_row_q;
		scan_col_d   = scan_col_q;
		phase_d      = phase_q;
		last_level_d = last_level_q;
		stable_cnt_d = stable_cnt_q;
		hold_cnt_d   = hold_cnt_q;

		res.key_valid = 1'b0;
		res.key_code  = KEY_NONE;
		for (int i = 0; i < 4; i++) begin
			res.row_drive[i] = (row3 != 3'(i));
		end

		unique case (phase_q)
			PH_HOLD: begin
				if (cfg.long_press_ticks == '0 || pin) begin
					res.key_valid = 1'b1;
					res.key_code  = KEY_STAR;
					go_next_row   = 1'b1;
				end else begin
					hold_inc   = (hold_cnt_q == 16'hFFFF) ? hold_cnt_q : hold_cnt_q + 16'd1;
					hold_cnt_d = hold_inc;
					if (hold_inc >= cfg.long_press_ticks) begin
						res.key_valid = 1'b1;
						res.key_code  = KEY_SHUTDOWN;
						go_next_row   = 1'b1;
					end
				end
			end
			PH_RELEASE: begin
				go_next_row = pin;
			end
			default: begin
				if (pin == last_level_q) begin
					cnt = (stable_cnt_q == 4'hF) ? stable_cnt_q : stable_cnt_q + 4'd1;
				end else begin
					cnt = '0;
				end
				last_level_d = pin;
				stable_cnt_d = cnt;
				if (cnt >= cfg.debounce_samples) begin
					if (pin) begin
						if ((4'(scan_col_q) + 4'd1) >= 4'(NUM_COLS)) begin
							go_next_row = 1'b1;
						end else begin
							scan_col_d   = scan_col_q + CW'(1);
							phase_d      = PH_DEBOUNCE;
							last_level_d = 1'b0;
							stable_cnt_d = '0;
							hold_cnt_d   = '0;
						end
					end else if (row3 == STAR_ROW && col3 == STAR_COL
						&& cfg.long_press_ticks != '0) begin
						phase_d    = PH_HOLD;
						hold_cnt_d = '0;
					end else begin
						res.key_valid = 1'b1;
						res.key_code  = key;
						case (cfg.release_mode)
							REL_NONE:   wait_rel = 1'b0;
							REL_MIDDLE: wait_rel = (col3 == MID_COL);
							default:    wait_rel = 1'b1;
						endcase
						if (wait_rel) begin
							phase_d = PH_RELEASE;
						end else begin
							go_next_row = 1'b1;
						end
					end
				end
			end
		endcase

		if (go_next_row) begin
			scan_row_d   = row_inc;
			scan_col_d   = '0;
			phase_d      = PH_DEBOUNCE;
			last_level_d = 1'b0;
			stable_cnt_d = '0;
			hold_cnt_d   = '0;
		end
	end

endmodule

// File: rtl/core/matrix_keypad_scanner.sv
// Channel  Direction  Beat contents
// s_*      in         tdata[2:0] column levels of one tick
// m_*      out        tdata[3:0] row drive, [4] key valid, [12:5] key code
// cfg_*    in         cfg_index register index, cfg_data value (low bits used)
//
// Every tick beat gives exactly one result beat; a new beat can enter every cycle
// while results are taken. A beat passes an input register and then the result register.
// Reset clears the scan state and loads the default settings.
// When the result register is full and not taken, the input register holds one more beat.
module matrix_keypad_scanner #(
	parameter int NUM_ROWS = kps_pkg::DEFAULT_NUM_ROWS,
	parameter int NUM_COLS = kps_pkg::DEFAULT_NUM_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // column_levels
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // row_drive, key_valid, key_code
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import kps_pkg::*;

	cfg_t       cfg_q;
	logic       in_valid_s1;
	logic [2:0] in_levels_s1;
	logic       out_valid_q;
	res_t       out_res_q;
	res_t       res;
	logic       advance;

	assign advance   = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !in_valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {3'b000, out_res_q.key_code, out_res_q.key_valid, out_res_q.row_drive};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_samples <= DEBOUNCE_RESET;
			cfg_q.release_mode     <= RELEASE_RESET;
			cfg_q.long_press_ticks <= LONG_PRESS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:   cfg_q.debounce_samples <= cfg_data[3:0];
				CFG_RELEASE:    cfg_q.release_mode     <= cfg_data[1:0];
				CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				in_valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_levels_s1 <= s_tdata[2:0];
		end
		if (advance) begin
			out_res_q <= res;
		end
	end

	kps_scan_core #(
		.NUM_ROWS(NUM_ROWS),
		.NUM_COLS(NUM_COLS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.levels(in_levels_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

endmodule
